@@ hw/rtl/dnle_pkg.sv @@
// ============================================================================
// dnle_pkg
// shared types and constants of the dns name label encoder
// ============================================================================
`default_nettype none

package dnle_pkg;

    localparam int BYTE_W        = 8;
    // label length and store index width, enough for any label cap up to 63
    localparam int CNT_W         = 6;
    localparam int LABEL_MAX_DEF = 62;

    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;
    localparam logic [BYTE_W-1:0] NUL_CHAR = 8'h00;

    // one input beat
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              end_of_name;
    } in_t;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              label_too_long;
    } out_t;

    // flush command from front to back
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic             ovf;
        logic             is_end;
        logic             bank;
    } cmd_t;

    // bank release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

@@ hw/rtl/dnle_ram.sv @@
// ============================================================================
// dnle_ram
// generic single write port, single read port ram with registered read
// ============================================================================
`default_nettype none

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 124
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dnle_cmdq.sv @@
// ============================================================================
// dnle_cmdq
// two-entry command queue between front and back
// ============================================================================
`default_nettype none

module dnle_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  dnle_pkg::cmd_t     wdata,
    output logic               full,
    input  wire logic          rd,
    output dnle_pkg::cmd_t     rdata,
    output logic               empty
);

    dnle_pkg::cmd_t mem_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wp_next  = do_wr ? !wp_reg : wp_reg;
        rp_next  = do_rd ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dnle_front.sv @@
// ============================================================================
// dnle_front
// accepts characters, stores labels into a two-bank store, issues flushes
// ============================================================================
`default_nettype none

module dnle_front #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int AW        = $clog2(2 * LABEL_MAX)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  dnle_pkg::in_t                item,
    output logic                         full,
    // store write port
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [dnle_pkg::BYTE_W-1:0]  ram_wdata,
    // command queue
    output logic                         cmd_wr,
    output dnle_pkg::cmd_t               cmd,
    input  wire logic                    cmd_full,
    // bank release from back
    input  dnle_pkg::rel_t               rel
);

    logic [dnle_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic                       bank_reg, bank_next;
    logic [1:0]                 busy_reg, busy_next;
    logic                       accept, is_dot, flush, store;
    logic                       has_room;

    // stall while the queue is full or the open bank is still being read out
    assign full     = cmd_full || busy_reg[bank_reg];
    assign accept   = push && !full;
    assign is_dot   = !item.end_of_name && (item.ch == dnle_pkg::DOT_CHAR);
    assign flush    = accept && (item.end_of_name || is_dot);
    assign store    = accept && !item.end_of_name && !is_dot;
    assign has_room = (count_reg < dnle_pkg::CNT_W'(LABEL_MAX));

    assign ram_we    = store && has_room;
    assign ram_waddr = bank_reg ? AW'(count_reg) + AW'(LABEL_MAX) : AW'(count_reg);
    assign ram_wdata = item.ch;

    assign cmd_wr     = flush;
    assign cmd.len    = count_reg;
    assign cmd.ovf    = ovf_reg;
    assign cmd.is_end = item.end_of_name;
    assign cmd.bank   = bank_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (flush)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            // empty labels read nothing, so the bank stays open
            if (count_reg != '0)
            begin
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
            end
        end
        else if (store)
        begin
            if (has_room)
            begin
                count_next = count_reg + dnle_pkg::CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dnle_back.sv @@
// ============================================================================
// dnle_back
// executes flush commands: length byte, stored characters, closing zero
// ============================================================================
`default_nettype none

module dnle_back #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int AW        = $clog2(2 * LABEL_MAX)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // command queue
    input  dnle_pkg::cmd_t               cmd,
    input  wire logic                    cmd_empty,
    output logic                         cmd_rd,
    // store read port
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  wire logic [dnle_pkg::BYTE_W-1:0] ram_rdata,
    // bank release to front
    output dnle_pkg::rel_t               rel,
    // result queue
    output logic                         empty,
    input  wire logic                    pop,
    output dnle_pkg::out_t               result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_RD   = 4'b0100,
        S_END  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    dnle_pkg::cmd_t             cur_reg, cur_next;
    logic [dnle_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       pend_reg, pend_next;

    dnle_pkg::out_t             oq_reg [2];
    logic                       wp_reg, wp_next;
    logic                       rp_reg, rp_next;
    logic [1:0]                 cnt_reg, cnt_next;

    logic                       direct_ok, read_ok;
    logic                       direct_wr, oq_wr, oq_rd;
    dnle_pkg::out_t             direct_beat, oq_wdata;
    logic                       last_idx;

    // a read in flight owns one slot of the result queue
    assign direct_ok = !pend_reg && (cnt_reg != 2'd2);
    assign read_ok   = ((cnt_reg + {1'b0, pend_reg}) < 2'd2);
    assign last_idx  = (idx_reg == cur_reg.len - dnle_pkg::CNT_W'(1));

    assign ram_raddr = cur_reg.bank ? AW'(idx_reg) + AW'(LABEL_MAX) : AW'(idx_reg);

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        cmd_rd      = 1'b0;
        ram_re      = 1'b0;
        rel.valid   = 1'b0;
        rel.bank    = cur_reg.bank;
        direct_wr   = 1'b0;
        direct_beat = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_rd   = 1'b1;
                    cur_next = cmd;
                    idx_next = '0;
                    // the root label at the end of a name has no length byte
                    if (!cmd.is_end || (cmd.len != '0))
                    begin
                        state_next = S_LEN;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_LEN:
            begin
                if (direct_ok)
                begin
                    direct_wr                  = 1'b1;
                    direct_beat.out_byte       = {{(dnle_pkg::BYTE_W - dnle_pkg::CNT_W){1'b0}},
                                                  cur_reg.len};
                    direct_beat.label_too_long = cur_reg.ovf;
                    if (cur_reg.len != '0)
                    begin
                        state_next = S_RD;
                    end
                    else if (cur_reg.is_end)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                if (read_ok)
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + dnle_pkg::CNT_W'(1);
                    if (last_idx)
                    begin
                        rel.valid  = 1'b1;
                        state_next = cur_reg.is_end ? S_END : S_IDLE;
                    end
                end
            end
            S_END:
            begin
                if (direct_ok)
                begin
                    direct_wr            = 1'b1;
                    direct_beat.out_byte = dnle_pkg::NUL_CHAR;
                    direct_beat.last     = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result queue
    assign empty  = (cnt_reg == 2'd0);
    assign result = oq_reg[rp_reg];
    assign oq_rd  = pop && !empty;
    assign oq_wr  = pend_reg || direct_wr;

    always_comb
    begin
        oq_wdata = direct_beat;
        if (pend_reg)
        begin
            oq_wdata.out_byte       = ram_rdata;
            oq_wdata.last           = 1'b0;
            oq_wdata.label_too_long = 1'b0;
        end
        pend_next = ram_re;
        wp_next   = oq_wr ? !wp_reg : wp_reg;
        rp_next   = oq_rd ? !rp_reg : rp_reg;
        cnt_next  = cnt_reg + {1'b0, oq_wr} - {1'b0, oq_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (oq_wr)
        begin
            oq_reg[wp_reg] <= oq_wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dns_name_label_encoder.sv @@
// ============================================================================
// dns_name_label_encoder
// dotted domain name to dns wire label format, one character per beat
// ============================================================================
// order: a character beat is stored and emits nothing; a dot or terminator is
//   registered in the command queue, then taken by back, which writes its results
// throughput: characters go in at 1 per cycle while full is low; a read in
//   flight holds a result slot, which can hold back stored characters; input
//   stalls while both banks hold unread labels or the command queue is full
// reset: control state cleared, store contents undefined, no clearing pass
`default_nettype none

module dns_name_label_encoder #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    // input queue side
    input  wire logic     push,
    input  dnle_pkg::in_t item,
    output logic          full,
    // result queue side
    output logic          empty,
    input  wire logic     pop,
    output dnle_pkg::out_t result
);

    // two banks of LABEL_MAX entries: front fills one while back drains the other
    localparam int DEPTH = 2 * LABEL_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [dnle_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [dnle_pkg::BYTE_W-1:0] ram_rdata;

    // flush commands between front and back
    logic           cmd_wr, cmd_rd, cmd_full, cmd_empty;
    dnle_pkg::cmd_t cmd_in, cmd_out;

    // bank handed back once its last character has been read
    dnle_pkg::rel_t rel;

    // front: takes beats, fills the open bank, classifies dots and terminators
    dnle_front #(
        .LABEL_MAX (LABEL_MAX),
        .AW        (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .cmd_wr    (cmd_wr),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full),
        .rel       (rel)
    );

    // short queue decoupling the two halves
    dnle_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .wdata (cmd_in),
        .full  (cmd_full),
        .rd    (cmd_rd),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    // label store
    dnle_ram #(
        .WIDTH (dnle_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: emits length byte, characters and closing zero into the result queue
    dnle_back #(
        .LABEL_MAX (LABEL_MAX),
        .AW        (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rel       (rel),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dnle_checker.sv @@
// ============================================================================
// dnle_sva
// port-level checks of the dns name label encoder
// ============================================================================
`default_nettype none

module dnle_sva #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     empty,
    input wire logic     pop,
    input dnle_pkg::out_t result
);

    // nothing waits on the result side right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // a waiting beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result beat changed");

    // closing zero never carries the overflow flag and is zero
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last) |-> (!result.label_too_long && result.out_byte == 8'h00))
        else $error("malformed closing beat");

    // a truncated label reports the cap as its length
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.label_too_long) |->
            (result.out_byte == dnle_pkg::BYTE_W'(LABEL_MAX)))
        else $error("overflow length byte not at cap");

endmodule

bind dns_name_label_encoder dnle_sva #(
    .LABEL_MAX (LABEL_MAX)
) u_dnle_sva (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

@@ sim/dnle_checker.sv @@
// ============================================================================
// dnle_checker
// predicts the wire bytes of the label encoder and compares every result beat
// ============================================================================
`default_nettype none

module dnle_checker
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic full,
    input  in_t       item,
    input  wire logic empty,
    input  wire logic pop,
    input  out_t      result,
    output int        errors,
    output int        due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BYTE_W-1:0] held_label [LABEL_MAX];
    logic [CNT_W-1:0]  held_len;
    logic              held_dropped;
    out_t              wire_due [$];

    function automatic out_t wire_beat(logic [BYTE_W-1:0] b, logic l, logic t);
        out_t w;
        w.out_byte       = b;
        w.last           = l;
        w.label_too_long = t;
        return w;
    endfunction

    // length byte, then the held characters; the label starts over
    task automatic emit_label();
        wire_due.push_back(wire_beat(BYTE_W'(held_len), 1'b0, held_dropped));
        for (int i = 0; i < held_len; i++)
            wire_due.push_back(wire_beat(held_label[i], 1'b0, 1'b0));
        held_len     = '0;
        held_dropped = 1'b0;
    endtask

    task automatic encode_beat(in_t beat);
        if (beat.end_of_name)
        begin
            // empty label at the end of a name gives no length byte
            if (held_len != 0 || held_dropped)
                emit_label();
            held_len     = '0;
            held_dropped = 1'b0;
            wire_due.push_back(wire_beat(NUL_CHAR, 1'b1, 1'b0));
        end
        else if (beat.ch == DOT_CHAR)
        begin
            emit_label();
        end
        else if (held_len < LABEL_MAX)
        begin
            held_label[held_len] = beat.ch;
            held_len             = held_len + 1'b1;
        end
        else
        begin
            held_dropped = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            held_len     = '0;
            held_dropped = 1'b0;
            wire_due.delete();
            errors       = 0;
            due_count    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (wire_due.size() == 0)
                begin
                    $error("unexpected result beat: out_byte %0h last %0b label_too_long %0b",
                           result.out_byte, result.last, result.label_too_long);
                    errors++;
                end
                else
                begin
                    want = wire_due.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0h, actual %0h",
                               want.out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, result.last);
                        errors++;
                    end
                    if (result.label_too_long !== want.label_too_long)
                    begin
                        $error("label_too_long: expected %0b, actual %0b",
                               want.label_too_long, result.label_too_long);
                        errors++;
                    end
                end
            end
            if (push && !full)
                encode_beat(item);
            due_count = wire_due.size();
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ============================================================================
// testbench
// stimulus and verdict for the dns name label encoder
// ============================================================================
// feeds dotted names one character per beat: a short list of corner cases
// (empty names, stray dots, zero and all-ones characters, full and overlong
// labels), then random names, mostly well formed with some noise; the
// checker beside the block predicts every wire byte and counts mismatches
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dnle_pkg::*;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic push  = 1'b0;
    logic pop   = 1'b0;
    in_t  item  = '0;
    logic full;
    logic empty;
    out_t result;

    int errors;
    int due_count;
    int beats_sent    = 0;
    // idle chance per cycle, in percent, for the sending and the receiving side
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    always #6 clk = ~clk;

    dns_name_label_encoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    dnle_checker label_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .errors    (errors),
        .due_count (due_count)
    );

    // receiver: one decision per cycle, made at the falling edge
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(0, 99) >= take_idle_pct);

    // one input beat; entered and left just after a falling edge
    task automatic send_beat(logic [BYTE_W-1:0] c, logic e);
        // random idle cycles ahead of the beat
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= in_t'{ch: c, end_of_name: e};
        // accepted at the first rising edge that sees full low
        do
            @(posedge clk);
        while (full);
        beats_sent++;
        @(negedge clk);
    endtask

    // terminator with a random character, which the block must ignore
    task automatic send_end();
        send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // mostly hostname characters, sometimes any byte but a dot
    function automatic logic [BYTE_W-1:0] pick_char();
        logic [BYTE_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = "a" + BYTE_W'($urandom_range(0, 25));
            5, 6:          c = "0" + BYTE_W'($urandom_range(0, 9));
            7:             c = "-";
            default:
            begin
                do
                    c = BYTE_W'($urandom_range(0, 255));
                while (c == DOT_CHAR);
            end
        endcase
        return c;
    endfunction

    task automatic send_label(int len);
        repeat (len)
            send_beat(pick_char(), 1'b0);
    endtask

    // short labels mostly, now and then a long, full or overlong one
    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 88)
            return $urandom_range(1, 12);
        else if (roll < 95)
            return $urandom_range(40, LABEL_MAX_DEF);
        else
            return $urandom_range(LABEL_MAX_DEF + 1, LABEL_MAX_DEF + 6);
    endfunction

    // one name: well formed most of the time, otherwise a broken shape
    task automatic send_name();
        int roll;
        int labels;
        roll   = $urandom_range(0, 99);
        labels = $urandom_range(1, 4);
        if (roll < 80)
        begin
            for (int i = 0; i < labels; i++)
            begin
                if (i != 0)
                    send_beat(DOT_CHAR, 1'b0);
                send_label(pick_len());
            end
            send_end();
        end
        else if (roll < 84)
        begin
            // empty name, root only
            send_end();
        end
        else if (roll < 88)
        begin
            // leading dot
            send_beat(DOT_CHAR, 1'b0);
            send_label(pick_len());
            send_end();
        end
        else if (roll < 92)
        begin
            // trailing dot, fully qualified form
            send_label(pick_len());
            send_beat(DOT_CHAR, 1'b0);
            send_end();
        end
        else
        begin
            // noise: any bytes, dots thrown in, runs of empty labels
            repeat ($urandom_range(1, 16))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_beat(DOT_CHAR, 1'b0);
                else
                    send_beat(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            send_end();
        end
    endtask

    initial
    begin
        // phase 1: sender rarely idles, receiver mostly stalls
        send_idle_pct = 7;
        take_idle_pct = 85;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty name: only the closing zero
        send_beat(NUL_CHAR, 1'b1);
        // lone dot then the end: zero length byte, then the closing zero
        send_beat(DOT_CHAR, 1'b0);
        send_end();
        // two dots in a row give an empty label in the middle
        send_beat("a", 1'b0);
        send_beat(DOT_CHAR, 1'b0);
        send_beat(DOT_CHAR, 1'b0);
        send_beat("b", 1'b0);
        send_beat(8'hFF, 1'b1);
        // trailing dot
        send_beat("x", 1'b0);
        send_beat(DOT_CHAR, 1'b0);
        send_beat(NUL_CHAR, 1'b1);
        // zero and all-ones are plain characters when not a terminator
        send_beat(NUL_CHAR, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        // a dot character on the terminator beat is ignored
        send_beat("q", 1'b0);
        send_beat(DOT_CHAR, 1'b1);

        // overlong at a dot, exactly full, overlong at the end
        send_label(LABEL_MAX_DEF + 1);
        send_beat(DOT_CHAR, 1'b0);
        send_label(LABEL_MAX_DEF);
        send_beat(DOT_CHAR, 1'b0);
        send_label(LABEL_MAX_DEF + 2);
        send_end();
        // full label at the end: the largest burst of results
        send_label(LABEL_MAX_DEF);
        send_end();

        while (beats_sent < 290)
            send_name();

        // phase 2: sender mostly idles, receiver rarely stalls
        send_idle_pct = 85;
        take_idle_pct = 7;
        while (beats_sent < 350)
            send_name();

        // phase 3: both sides at full rate
        send_idle_pct = 0;
        take_idle_pct = 0;
        while (beats_sent < 410)
            send_name();

        push <= 1'b0;

        // drain, then give any stray beat time to show up
        while (due_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && due_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
